FILE: rtl/qxmm_pkg.sv
// Package: shared constants and types for the quad X motor mixer.
`timescale 1ns / 1ps
package qxmm_pkg;
  localparam int DataW = 32;
  localparam int ArmW = 19;
  localparam int RatioW = 32;
  localparam int LimitW = 31;
  localparam int RatioFracBits = 28;
  localparam logic [31:0] InvSqrt2Q32 = 32'd3037000500;
  localparam logic [31:0] RatioFloor = 32'd2684;

  typedef enum logic [1:0] {
    CFG_ARM_RADIUS = 2'd0,
    CFG_YAW_RATIO  = 2'd1,
    CFG_MAX_THRUST = 2'd2
  } cfg_idx_t;
endpackage

FILE: rtl/qxmm_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed saturating result.
`timescale 1ns / 1ps
module qxmm_div #(
  parameter int SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic signed [31:0] in_num,
  input  logic [35:0] in_den,
  output logic        out_valid,
  output logic signed [31:0] out_quot
);
  import qxmm_pkg::*;

  // dividend = |num| << SHIFT; quotient bits above 32 only matter as overflow
  localparam int NW = 32 + SHIFT;
  localparam int STG = NW;

  logic [NW-1:0] num_r [STG+1];
  logic [36:0]   rem_r [STG+1];
  logic [35:0]   den_r [STG+1];
  logic          neg_r [STG+1];
  logic          ovf_r [STG+1];
  logic [STG:0]  vld_r;

  logic [31:0] mag;
  assign mag = in_num[31] ? (~in_num + 32'd1) : in_num;

  always_ff @(posedge clk) begin
    num_r[0] <= {mag, {SHIFT{1'b0}}};
    rem_r[0] <= '0;
    den_r[0] <= in_den;
    neg_r[0] <= in_num[31];
    ovf_r[0] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STG-1:0], in_valid};
    end
  end

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [36:0] trial;
    logic        ge;
    assign trial = {rem_r[s][35:0], num_r[s][NW-1]};
    assign ge = trial >= {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? (trial - {1'b0, den_r[s]}) : trial;
      num_r[s+1] <= {num_r[s][NW-2:0], ge};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      // quotient bits 32 and up force saturation
      ovf_r[s+1] <= ovf_r[s] | (ge && (s < NW - 32));
    end
  end

  logic [31:0] q;
  logic signed [31:0] res;
  assign q = num_r[STG][31:0];
  always_comb begin
    if (neg_r[STG]) begin
      res = (ovf_r[STG] || q >= 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q);
    end else begin
      res = (ovf_r[STG] || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    out_quot <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[STG];
    end
  end
endmodule

FILE: rtl/quad_x_motor_mixer_core.sv
// Top level: quad X-frame motor mixer, fully pipelined.
// The yaw divider (28 + 32 stages plus input and output registers) sets the path from
// start to out_valid, and four mixing stages follow it.
// Throughput: one beat per cycle; busy is tied low, start is always taken.
// The long chain is the three pipelined dividers, one quotient bit a stage.
// Reset (rst_n, synchronous) clears the valid pipe and loads register defaults.
// Results appear for one cycle with out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module quad_x_motor_mixer_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_collective_thrust,
  input  logic signed [31:0] in_pitch_torque,
  input  logic signed [31:0] in_yaw_torque,
  input  logic signed [31:0] in_roll_torque,
  output logic        out_valid,
  output logic [30:0] out_motor0_thrust,
  output logic [30:0] out_motor1_thrust,
  output logic [30:0] out_motor2_thrust,
  output logic [30:0] out_motor3_thrust,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import qxmm_pkg::*;

  localparam int DivLat = 32 + FRACTION_BITS + 1;
  localparam int YawLat = 32 + RatioFracBits + 1;
  localparam int YawExtra = YawLat - DivLat;  // pitch/roll wait this long
  localparam logic [31:0] CFloorRaw = 32'(((1 << FRACTION_BITS) + 5000) / 10000);
  localparam logic [31:0] CFloor = (CFloorRaw < 32'd1) ? 32'd1 : CFloorRaw;

  assign busy = 1'b0;

  // config registers
  logic [ArmW-1:0]   arm_r;
  logic [RatioW-1:0] ratio_r;
  logic [LimitW-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_r   <= ArmW'(15073);
      ratio_r <= RatioW'(4026532);
      limit_r <= LimitW'(655360);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ARM_RADIUS: arm_r   <= cfg_wdata[ArmW-1:0];
        CFG_YAW_RATIO:  ratio_r <= cfg_wdata;
        CFG_MAX_THRUST: limit_r <= cfg_wdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // divisors from config; the user must keep them static while items are in flight, the block does not enforce it
  logic [50:0] arm_prod;
  logic [31:0] coord;
  logic [31:0] ratio_fl;
  logic [35:0] den_c;
  logic [35:0] den_y;
  assign arm_prod = 51'(arm_r) * 51'(InvSqrt2Q32);
  assign coord    = (32'(arm_prod[50:32]) < CFloor) ? CFloor : 32'(arm_prod[50:32]);
  assign ratio_fl = (ratio_r < RatioFloor) ? RatioFloor : ratio_r;
  assign den_c    = {2'b00, coord, 2'b00};
  assign den_y    = {2'b00, ratio_fl, 2'b00};

  // base thrust travels beside the dividers
  logic [29:0] base_in;
  assign base_in = in_collective_thrust[31] ? 30'd0 : in_collective_thrust[31:2];

  logic [29:0] base_d_r [YawLat+1];
  always_ff @(posedge clk) begin
    base_d_r[0] <= base_in;
    for (int i = 1; i <= YawLat; i++) base_d_r[i] <= base_d_r[i-1];
  end

  logic p_v, r_v, y_v;
  logic signed [31:0] p_q, r_q, y_q;

  qxmm_div #(.SHIFT(FRACTION_BITS)) u_div_p (
    .clk, .rst_n, .in_valid(start), .in_num(in_pitch_torque), .in_den(den_c),
    .out_valid(p_v), .out_quot(p_q));
  qxmm_div #(.SHIFT(FRACTION_BITS)) u_div_r (
    .clk, .rst_n, .in_valid(start), .in_num(in_roll_torque), .in_den(den_c),
    .out_valid(r_v), .out_quot(r_q));
  qxmm_div #(.SHIFT(RatioFracBits)) u_div_y (
    .clk, .rst_n, .in_valid(start), .in_num(in_yaw_torque), .in_den(den_y),
    .out_valid(y_v), .out_quot(y_q));

  // align pitch/roll with the longer yaw divider
  logic signed [31:0] p_d_r [YawExtra];
  logic signed [31:0] r_d_r [YawExtra];
  always_ff @(posedge clk) begin
    p_d_r[0] <= p_q;
    r_d_r[0] <= r_q;
    for (int k = 1; k < YawExtra; k++) begin
      p_d_r[k] <= p_d_r[k-1];
      r_d_r[k] <= r_d_r[k-1];
    end
  end

  // stage A: motor sums (36-bit signed is enough: 30-bit base + three 32-bit)
  logic signed [35:0] m_r [4];
  logic               a_v_r;
  logic signed [35:0] b, p, r, y;
  assign b = 36'(signed'({1'b0, base_d_r[YawLat]}));
  assign p = 36'(p_d_r[YawExtra-1]);
  assign r = 36'(r_d_r[YawExtra-1]);
  assign y = 36'(y_q);

  always_ff @(posedge clk) begin
    m_r[0] <= b - p - r + y;
    m_r[1] <= b - p + r - y;
    m_r[2] <= b + p + r + y;
    m_r[3] <= b + p - r - y;
  end

  // stage B: min and max
  logic signed [35:0] mB_r [4];
  logic signed [35:0] lo_r, hi_r;
  logic               b_v_r;
  logic signed [35:0] lo01, lo23, hi01, hi23;
  assign lo01 = (m_r[1] < m_r[0]) ? m_r[1] : m_r[0];
  assign lo23 = (m_r[3] < m_r[2]) ? m_r[3] : m_r[2];
  assign hi01 = (m_r[1] > m_r[0]) ? m_r[1] : m_r[0];
  assign hi23 = (m_r[3] > m_r[2]) ? m_r[3] : m_r[2];
  always_ff @(posedge clk) begin
    mB_r <= m_r;
    lo_r <= (lo23 < lo01) ? lo23 : lo01;
    hi_r <= (hi23 > hi01) ? hi23 : hi01;
  end

  // stage C: raise by deficit
  logic signed [36:0] mC_r [4];
  logic signed [36:0] hiC_r;
  logic               c_v_r;
  logic signed [36:0] sh;
  assign sh = lo_r[35] ? 37'(lo_r) : 37'sd0;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) mC_r[i] <= 37'(mB_r[i]) - sh;
    hiC_r <= 37'(hi_r) - sh;
  end

  // stage D: lower by excess, clamp
  logic signed [36:0] lim;
  logic signed [36:0] red;
  logic signed [36:0] v [4];
  logic [30:0]        o [4];
  assign lim = 37'(signed'({1'b0, limit_r}));
  assign red = (lim > 0 && hiC_r > lim) ? (hiC_r - lim) : 37'sd0;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      v[i] = mC_r[i] - red;
      if (v[i] < 0) o[i] = '0;
      else if (v[i] > lim) o[i] = limit_r;
      else o[i] = v[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    out_motor0_thrust <= o[0];
    out_motor1_thrust <= o[1];
    out_motor2_thrust <= o[2];
    out_motor3_thrust <= o[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_v_r <= y_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      out_valid <= c_v_r;
    end
  end

  logic unused_v;
  assign unused_v = p_v ^ r_v;
endmodule

FILE: rtl/qxmm_checker.sv
// Checker: port-level properties of the mixer, bound to the top level.
`timescale 1ns / 1ps
module qxmm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [30:0] out_motor0_thrust,
  input logic [30:0] out_motor1_thrust,
  input logic [30:0] out_motor2_thrust,
  input logic [30:0] out_motor3_thrust
);
  a_busy_low: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
  a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid))
    else $error("out_valid unknown");
  a_motors_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_motor0_thrust, out_motor1_thrust,
                               out_motor2_thrust, out_motor3_thrust}))
    else $error("motor thrust unknown on a valid beat");
endmodule

bind quad_x_motor_mixer_core qxmm_checker u_qxmm_checker (
  .clk, .rst_n, .busy, .out_valid,
  .out_motor0_thrust, .out_motor1_thrust, .out_motor2_thrust, .out_motor3_thrust);

FILE: dv/quad_x_motor_mixer_core_tb.sv
// Testbench for the quad X motor mixer: directed table plus random beats, checked by a predictor.
`timescale 1ns / 1ps
module quad_x_motor_mixer_core_tb;
  import qxmm_pkg::*;

  localparam int FracBits = 16;
  localparam int Latency = RatioFracBits + 37;
  localparam int NumRandom = 1600;

  typedef struct packed {
    logic [30:0] m0;
    logic [30:0] m1;
    logic [30:0] m2;
    logic [30:0] m3;
  } thrust_set_t;

  typedef struct {
    logic signed [31:0] coll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] roll;
    bit                 has_gold;   // expected thrusts typed in below
    thrust_set_t        gold;
  } demand_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic signed [31:0] in_collective_thrust = '0;
  logic signed [31:0] in_pitch_torque = '0;
  logic signed [31:0] in_yaw_torque = '0;
  logic signed [31:0] in_roll_torque = '0;
  logic        out_valid;
  logic [30:0] out_motor0_thrust, out_motor1_thrust, out_motor2_thrust, out_motor3_thrust;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Predictor copy of the register file.
  logic [18:0] arm_q = 19'd15073;
  logic [31:0] ratio_q = 32'd4026532;
  logic [30:0] limit_q = 31'd655360;

  thrust_set_t pending_thrusts[$];
  int errors = 0;
  int beats_checked = 0;
  int idle_pct = 0;

  always #10 clk = ~clk;

  quad_x_motor_mixer_core #(.FRACTION_BITS(FracBits)) u_dut (.*);

  // Signed (t << sh) / den, truncated toward zero, clipped to 32-bit signed.
  function automatic longint torque_share(longint t, int sh, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (t < 0) ? longint'(-t) : longint'(t);
    q = (mag << sh) / den;
    if (t < 0) return (q >= 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic thrust_set_t mix_thrusts(logic signed [31:0] coll, logic signed [31:0] pt,
                                              logic signed [31:0] yt, logic signed [31:0] rt);
    longint unsigned cfloor, coord, ratio;
    longint base, p, r, y, lo, hi, lim, v;
    longint m[4];
    logic [30:0] o[4];
    thrust_set_t res;
    cfloor = ((64'd1 << FracBits) + 5000) / 10000;
    if (cfloor < 1) cfloor = 1;
    base = (coll < 0) ? 0 : (longint'(coll) >>> 2);
    coord = (longint'(arm_q) * 64'd3037000500) >> 32;
    if (coord < cfloor) coord = cfloor;
    ratio = (ratio_q < RatioFloor) ? RatioFloor : ratio_q;
    p = torque_share(pt, FracBits, 4 * coord);
    r = torque_share(rt, FracBits, 4 * coord);
    y = torque_share(yt, RatioFracBits, 4 * ratio);
    m[0] = base - p - r + y;
    m[1] = base - p + r - y;
    m[2] = base + p + r + y;
    m[3] = base + p - r - y;
    lo = m[0];
    hi = m[0];
    for (int i = 1; i < 4; i++) begin
      if (m[i] < lo) lo = m[i];
      if (m[i] > hi) hi = m[i];
    end
    lim = limit_q;
    if (lo < 0) begin
      for (int i = 0; i < 4; i++) m[i] -= lo;
      hi -= lo;
    end
    if (lim > 0 && hi > lim)
      for (int i = 0; i < 4; i++) m[i] -= hi - lim;
    for (int i = 0; i < 4; i++) begin
      v = m[i];
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      o[i] = v[30:0];
    end
    res.m0 = o[0];
    res.m1 = o[1];
    res.m2 = o[2];
    res.m3 = o[3];
    return res;
  endfunction

  // Register write; only issued with the pipe drained.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ARM_RADIUS: arm_q = val[18:0];
      CFG_YAW_RATIO:  ratio_q = val;
      CFG_MAX_THRUST: limit_q = val[30:0];
      default: ;   // out-of-range index: ignored by the block
    endcase
  endtask

  // Index 3 has no register; the block must ignore the write.
  task automatic write_bad_index(logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One beat: optional idle cycles first, start held until accepted.
  // start stays high across back-to-back beats; dropped on idle cycles and by drain.
  task automatic send_demand(demand_row_t row);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_collective_thrust <= row.coll;
    in_pitch_torque <= row.pitch;
    in_yaw_torque <= row.yaw;
    in_roll_torque <= row.roll;
    pending_thrusts.push_back(row.has_gold ? row.gold
                              : mix_thrusts(row.coll, row.pitch, row.yaw, row.roll));
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_thrusts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(32'h0040_0000, 0);        // modest positive
      3: return -$signed($urandom_range(32'h0040_0000, 0));
      default: return $urandom;
    endcase
  endfunction

  // Mostly realistic demands, rest wide noise.
  task automatic random_demands(int n);
    demand_row_t row;
    for (int k = 0; k < n; k++) begin
      row.has_gold = 1'b0;
      if ($urandom_range(3, 0) != 0) begin
        row.coll = $urandom_range(32'h0050_0000, 0);
        row.pitch = $signed($urandom_range(32'h0000_4000, 0)) - 32'sh2000;
        row.yaw = $signed($urandom_range(32'h0000_1000, 0)) - 32'sh0800;
        row.roll = $signed($urandom_range(32'h0000_4000, 0)) - 32'sh2000;
      end else begin
        row.coll = rand_field();
        row.pitch = rand_field();
        row.yaw = rand_field();
        row.roll = rand_field();
      end
      send_demand(row);
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    thrust_set_t exp_t;
    if (rst_n && out_valid) begin
      if (pending_thrusts.size() == 0) begin
        $display("%0t: unexpected result m0=%0d m1=%0d m2=%0d m3=%0d", $time,
                 out_motor0_thrust, out_motor1_thrust, out_motor2_thrust, out_motor3_thrust);
        errors++;
      end else begin
        exp_t = pending_thrusts.pop_front();
        beats_checked++;
        if (out_motor0_thrust !== exp_t.m0) begin
          $display("%0t: motor0 expected %0d actual %0d", $time, exp_t.m0, out_motor0_thrust);
          errors++;
        end
        if (out_motor1_thrust !== exp_t.m1) begin
          $display("%0t: motor1 expected %0d actual %0d", $time, exp_t.m1, out_motor1_thrust);
          errors++;
        end
        if (out_motor2_thrust !== exp_t.m2) begin
          $display("%0t: motor2 expected %0d actual %0d", $time, exp_t.m2, out_motor2_thrust);
          errors++;
        end
        if (out_motor3_thrust !== exp_t.m3) begin
          $display("%0t: motor3 expected %0d actual %0d", $time, exp_t.m3, out_motor3_thrust);
          errors++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    demand_row_t dir_rows[$];
    thrust_set_t zero_t;
    demand_row_t row;
    zero_t = '0;
    // Directed table (reset registers unless noted). gold only where obvious.
    // Hover: all zero.
    dir_rows.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, zero_t});
    // Negative collective clips to zero.
    dir_rows.push_back('{32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0, 1'b1, zero_t});
    // 4 N collective: each motor 1 N.
    dir_rows.push_back('{32'sh0004_0000, 32'sd0, 32'sd0, 32'sd0, 1'b1,
                         '{31'h10000, 31'h10000, 31'h10000, 31'h10000}});
    // Max collective: all clipped down to the 10 N limit.
    dir_rows.push_back('{32'sh7fff_ffff, 32'sd0, 32'sd0, 32'sd0, 1'b1,
                         '{31'd655360, 31'd655360, 31'd655360, 31'd655360}});
    // Torque extremes: quotients saturate.
    dir_rows.push_back('{32'sh0004_0000, 32'sh7fff_ffff, 32'sd0, 32'sd0, 1'b0, zero_t});
    dir_rows.push_back('{32'sh0004_0000, 32'sh8000_0000, 32'sd0, 32'sd0, 1'b0, zero_t});
    dir_rows.push_back('{32'sh0004_0000, 32'sd0, 32'sh7fff_ffff, 32'sd0, 1'b0, zero_t});
    dir_rows.push_back('{32'sh0004_0000, 32'sd0, 32'sh8000_0000, 32'sd0, 1'b0, zero_t});
    dir_rows.push_back('{32'sh0004_0000, 32'sd0, 32'sd0, 32'sh7fff_ffff, 1'b0, zero_t});
    dir_rows.push_back('{32'sh0004_0000, 32'sd0, 32'sd0, 32'sh8000_0000, 1'b0, zero_t});
    dir_rows.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                         1'b0, zero_t});
    dir_rows.push_back('{32'sh0008_0000, 32'sh0000_1000, -32'sh0000_0100, 32'sh0000_0800,
                         1'b0, zero_t});
    dir_rows.push_back('{32'sh0008_0000, -32'sh0000_1000, 32'sh0000_0100, -32'sh0000_0800,
                         1'b0, zero_t});
    dir_rows.push_back('{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                         1'b0, zero_t});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_demand(dir_rows[i]);
    drain();

    // Tiny arm, tiny ratio, zero limit; bad index must leave registers alone.
    write_reg(CFG_ARM_RADIUS, 32'd0);
    write_reg(CFG_YAW_RATIO, 32'd0);
    write_reg(CFG_MAX_THRUST, 32'd0);
    write_bad_index(32'hffff_ffff);
    send_demand('{32'sh7fff_ffff, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1, zero_t});
    send_demand('{32'sh0010_0000, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 1'b1, zero_t});
    drain();
    // Top extremes: widest arm, largest ratio, largest limit.
    write_reg(CFG_ARM_RADIUS, 32'h7ffff);
    write_reg(CFG_YAW_RATIO, 32'hffff_ffff);
    write_reg(CFG_MAX_THRUST, 32'h7fff_ffff);
    for (int k = 0; k < 6; k++) begin
      row = '{rand_field(), rand_field(), rand_field(), rand_field(), 1'b0, zero_t};
      send_demand(row);
    end
    drain();

    // Random phases, each with its own register setting; the idle mix repeats every four phases.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 60;
        2: idle_pct = 13;
        default: idle_pct = 30;
      endcase
      write_reg(CFG_ARM_RADIUS, (ph == 0) ? 32'd15073 : $urandom_range(327680, 1311));
      write_reg(CFG_YAW_RATIO, (ph == 0) ? 32'd4026532 : $urandom_range(32'hffff_ffff, 2684));
      write_reg(CFG_MAX_THRUST, (ph == 3) ? 32'd0
                : (ph == 0) ? 32'd655360 : $urandom_range(32'h7fff_ffff, 0));
      random_demands(NumRandom / 8);
      // Hold off until the pipe is empty before touching registers.
      drain();
    end

    repeat (Latency + 10) @(posedge clk);
    $display("Checked %0d mixer beats over directed extremes and 8 random register settings,",
             beats_checked);
    $display("with sender idle ratios of 0, 13, 30 and 60 percent.");
    if (errors == 0 && pending_thrusts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
